FILE: design/dmwc_pkg.sv
`default_nettype none
package dmwc_pkg;

  localparam logic [2:0] FUNC_READ  = 3'd0;
  localparam logic [2:0] FUNC_WRITE = 3'd1;
  localparam logic [2:0] FUNC_ZERO  = 3'd2;
  localparam logic [2:0] FUNC_FLUSH = 3'd3;
  localparam logic [2:0] FUNC_FILL  = 3'd4;

  localparam logic [3:0] MAX_BYTES = 4'd8;

  typedef enum logic [2:0] {
    OP_READ,
    OP_WRITE,
    OP_ZERO,
    OP_FLUSH,
    OP_FILL,
    OP_BAD
  } op_e;

  typedef enum logic [1:0] {
    KIND_DONE  = 2'd0,
    KIND_WB    = 2'd1,
    KIND_FETCH = 2'd2,
    KIND_ERR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_HOLD
  } fstate_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ERR,
    S_META,
    S_ACC,
    S_RD0,
    S_RD1,
    S_RD2,
    S_WR1,
    S_ZERO,
    S_WB_RD,
    S_WB_EM,
    S_FETCH,
    S_DONE
  } bstate_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] cluster;
    logic [7:0]  offset;
    logic [3:0]  count;
    logic [63:0] wdata;
  } req_t;

  typedef struct packed {
    logic        valid;
    logic        dirty;
    logic [31:0] tag;
  } meta_t;

endpackage
`default_nettype wire

FILE: design/dmwc_front.sv
`default_nettype none
module dmwc_front #(
  parameter int LINES = 16,
  parameter int IDXW  = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              hold_i,
  input  wire logic              push_i,
  output logic                   full_o,
  input  wire logic [2:0]        func_i,
  input  wire logic [31:0]       cluster_i,
  input  wire logic [7:0]        offset_i,
  input  wire logic [3:0]        byte_count_i,
  input  wire logic [63:0]       wdata_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output dmwc_pkg::req_t         q_req_o,
  output logic [IDXW-1:0]        q_idx_o
);
  import dmwc_pkg::*;

  localparam bit POW2 = (LINES & (LINES - 1)) == 0;
  // ceil(2^(32+IDXW) / LINES): exact quotient for every 32-bit cluster
  localparam logic [63:0] RECIP =
    ((64'd1 << (32 + IDXW)) + 64'(LINES) - 64'd1) / 64'(LINES);
  localparam logic [16:0] RECIP_LO = RECIP[16:0];
  localparam logic [16:0] RECIP_HI = RECIP[33:17];

  fstate_e          fstate_q, fstate_d;
  req_t             req_q, req_d;
  logic [IDXW-1:0]  idx_q, idx_d;
  logic [1:0]       div_cnt_q, div_cnt_d;
  logic [65:0]      prod_q, prod_d;
  logic [48:0]      part;
  logic [IDXW-1:0]  quo_lo;
  logic             accept;

  assign full_o   = hold_i || (fstate_q == F_DIV) || (fstate_q == F_HOLD && q_full_i);
  assign accept   = push_i && !full_o;
  assign q_push_o = (fstate_q == F_HOLD) && !q_full_i;
  assign q_req_o  = req_q;
  assign q_idx_o  = idx_q;

  always_comb begin
    fstate_d  = fstate_q;
    req_d     = req_q;
    idx_d     = idx_q;
    div_cnt_d = div_cnt_q;
    prod_d    = prod_q;
    // cluster times the reciprocal, low then high half
    part   = 49'(req_q.cluster) * 49'((div_cnt_q == 2'd0) ? RECIP_LO : RECIP_HI);
    quo_lo = IDXW'(prod_q >> (32 + IDXW));
    case (fstate_q)
      F_DIV: begin
        div_cnt_d = div_cnt_q + 2'd1;
        if (div_cnt_q == 2'd0) begin
          prod_d = 66'(part);
        end else if (div_cnt_q == 2'd1) begin
          prod_d = prod_q + (66'(part) << 17);
        end else begin
          // remainder fits in IDXW bits, so low bits of x - q*LINES suffice
          idx_d    = req_q.cluster[IDXW-1:0] - IDXW'(quo_lo * IDXW'(LINES));
          fstate_d = F_HOLD;
        end
      end
      F_IDLE, F_HOLD: begin
        if (fstate_q == F_HOLD && !q_full_i) begin
          fstate_d = F_IDLE;
        end
        if (accept) begin
          case (func_i)
            FUNC_READ:  req_d.op = OP_READ;
            FUNC_WRITE: req_d.op = OP_WRITE;
            FUNC_ZERO:  req_d.op = OP_ZERO;
            FUNC_FLUSH: req_d.op = OP_FLUSH;
            FUNC_FILL:  req_d.op = OP_FILL;
            default:    req_d.op = OP_BAD;
          endcase
          req_d.cluster = cluster_i;
          req_d.offset  = offset_i;
          req_d.count   = (byte_count_i > MAX_BYTES) ? MAX_BYTES : byte_count_i;
          req_d.wdata   = wdata_i;
          div_cnt_d     = 2'd0;
          if (POW2) begin
            idx_d    = IDXW'(cluster_i & 32'(LINES - 1));
            fstate_d = F_HOLD;
          end else begin
            idx_d    = '0;
            fstate_d = F_DIV;
          end
        end
      end
      default: fstate_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fstate_q  <= F_IDLE;
      div_cnt_q <= '0;
    end else begin
      fstate_q  <= fstate_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    idx_q  <= idx_d;
    prod_q <= prod_d;
  end

endmodule
`default_nettype wire

FILE: design/dmwc_fifo.sv
`default_nettype none
module dmwc_fifo #(
  parameter int IDXW = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  output logic                 full_o,
  input  wire dmwc_pkg::req_t  req_i,
  input  wire logic [IDXW-1:0] idx_i,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output dmwc_pkg::req_t       req_o,
  output logic [IDXW-1:0]      idx_o
);
  import dmwc_pkg::*;

  req_t            req_mem [2];
  logic [IDXW-1:0] idx_mem [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign req_o   = req_mem[rd_ptr_q];
  assign idx_o   = idx_mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      req_mem[wr_ptr_q] <= req_i;
      idx_mem[wr_ptr_q] <= idx_i;
    end
  end

endmodule
`default_nettype wire

FILE: design/dmwc_back.sv
`default_nettype none
module dmwc_back #(
  parameter int LINES         = 16,
  parameter int CLUSTER_BYTES = 256,
  parameter int IDXW          = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  output logic                 clearing_o,
  input  wire logic            q_empty_i,
  input  wire dmwc_pkg::req_t  q_req_i,
  input  wire logic [IDXW-1:0] q_idx_i,
  output logic                 q_pop_o,
  output logic                 empty_o,
  input  wire logic            pop_i,
  output logic [1:0]           kind_o,
  output logic [31:0]          target_cluster_o,
  output logic [63:0]          beat_data_o,
  output logic [4:0]           beat_index_o,
  output logic [3:0]           bytes_done_o,
  output logic                 last_o
);
  import dmwc_pkg::*;

  localparam int BEATS = (CLUSTER_BYTES + 7) / 8;
  localparam int WORDS = LINES * BEATS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BCW   = (BEATS > 1) ? $clog2(BEATS) : 1;
  localparam int TAIL  = CLUSTER_BYTES - (BEATS - 1) * 8;
  localparam logic [7:0] TAIL_MASK = 8'((9'd1 << TAIL) - 9'd1);

  // storage
  meta_t       meta_mem [LINES];
  logic [63:0] data_mem [WORDS];

  logic            meta_we;
  logic [IDXW-1:0] meta_waddr, meta_raddr;
  meta_t           meta_wdata, meta_rdata_q;
  logic            data_we, data_re;
  logic [AW-1:0]   data_waddr, data_raddr;
  logic [63:0]     data_wdata, data_rdata_q;

  bstate_e         state_q, state_d;
  logic [IDXW-1:0] clr_idx_q, clr_idx_d;
  logic            fill_pending_q, fill_pending_d;
  logic [BCW-1:0]  fill_cnt_q, fill_cnt_d;
  req_t            held_req_q, held_req_d;
  logic [IDXW-1:0] held_idx_q, held_idx_d;
  logic [AW-1:0]   held_base_q, held_base_d;
  req_t            cur_req_q, cur_req_d;
  logic [IDXW-1:0] cur_idx_q, cur_idx_d;
  logic [AW-1:0]   cur_base_q, cur_base_d;
  logic            cur_dirty_q, cur_dirty_d;
  logic [BCW-1:0]  beat_q, beat_d;
  logic [31:0]     wb_cl_q, wb_cl_d;
  logic            wb_miss_q, wb_miss_d;
  logic [63:0]     d0_q, d0_d;
  logic [63:0]     hi_word_q, hi_word_d;
  logic            hi_we_q, hi_we_d;
  logic [63:0]     res_data_q, res_data_d;
  logic [3:0]      res_bytes_q, res_bytes_d;

  logic            out_valid_q, out_valid_d;
  kind_e           out_kind_q, out_kind_d;
  logic [31:0]     out_cl_q, out_cl_d;
  logic [63:0]     out_data_q, out_data_d;
  logic [4:0]      out_bidx_q, out_bidx_d;
  logic [3:0]      out_bytes_q, out_bytes_d;
  logic            out_last_q, out_last_d;
  logic            out_ready;

  // access datapath
  logic [31:0]  off32;
  logic [3:0]   nbytes;
  logic [7:0]   bmask;
  logic [2:0]   sft;
  logic [15:0]  mask16;
  logic [127:0] wd128, old128, merged, rd128;
  logic [63:0]  rd_val, bm_wide;
  logic [63:0]  wb_val;
  logic         wb_last;
  logic         hit;

  assign clearing_o       = state_q == S_CLEAR;
  assign empty_o          = !out_valid_q;
  assign kind_o           = out_kind_q;
  assign target_cluster_o = out_cl_q;
  assign beat_data_o      = out_data_q;
  assign beat_index_o     = out_bidx_q;
  assign bytes_done_o     = out_bytes_q;
  assign last_o           = out_last_q;
  assign out_ready        = !out_valid_q || pop_i;

  always_comb begin
    off32 = 32'(cur_req_q.offset);
    if (off32 >= 32'(CLUSTER_BYTES)) begin
      nbytes = 4'd0;
    end else if (32'(CLUSTER_BYTES) - off32 < 32'(cur_req_q.count)) begin
      nbytes = 4'(32'(CLUSTER_BYTES) - off32);
    end else begin
      nbytes = cur_req_q.count;
    end
    bmask  = 8'((9'd1 << nbytes) - 9'd1);
    sft    = cur_req_q.offset[2:0];
    mask16 = 16'(bmask) << sft;
    wd128  = 128'(cur_req_q.wdata) << {sft, 3'b000};
    old128 = {data_rdata_q, d0_q};
    for (int i = 0; i < 16; i++) begin
      merged[i*8 +: 8] = mask16[i] ? wd128[i*8 +: 8] : old128[i*8 +: 8];
    end
    for (int i = 0; i < 8; i++) begin
      bm_wide[i*8 +: 8] = {8{bmask[i]}};
    end
    rd128  = old128 >> {sft, 3'b000};
    rd_val = rd128[63:0] & bm_wide;
    wb_last = beat_q == BCW'(BEATS - 1);
    wb_val  = data_rdata_q;
    if (wb_last) begin
      for (int i = 0; i < 8; i++) begin
        wb_val[i*8 +: 8] = TAIL_MASK[i] ? data_rdata_q[i*8 +: 8] : 8'd0;
      end
    end
    hit = meta_rdata_q.valid && (meta_rdata_q.tag == cur_req_q.cluster);
  end

  always_comb begin
    state_d        = state_q;
    clr_idx_d      = clr_idx_q;
    fill_pending_d = fill_pending_q;
    fill_cnt_d     = fill_cnt_q;
    held_req_d     = held_req_q;
    held_idx_d     = held_idx_q;
    held_base_d    = held_base_q;
    cur_req_d      = cur_req_q;
    cur_idx_d      = cur_idx_q;
    cur_base_d     = cur_base_q;
    cur_dirty_d    = cur_dirty_q;
    beat_d         = beat_q;
    wb_cl_d        = wb_cl_q;
    wb_miss_d      = wb_miss_q;
    d0_d           = d0_q;
    hi_word_d      = hi_word_q;
    hi_we_d        = hi_we_q;
    res_data_d     = res_data_q;
    res_bytes_d    = res_bytes_q;
    out_valid_d    = out_valid_q && !pop_i;
    out_kind_d     = out_kind_q;
    out_cl_d       = out_cl_q;
    out_data_d     = out_data_q;
    out_bidx_d     = out_bidx_q;
    out_bytes_d    = out_bytes_q;
    out_last_d     = out_last_q;
    q_pop_o        = 1'b0;
    meta_we        = 1'b0;
    meta_waddr     = cur_idx_q;
    meta_wdata     = '0;
    meta_raddr     = q_idx_i;
    data_we        = 1'b0;
    data_waddr     = cur_base_q;
    data_wdata     = '0;
    data_re        = 1'b0;
    data_raddr     = cur_base_q;

    case (state_q)
      S_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_idx_q;
        clr_idx_d  = clr_idx_q + IDXW'(1);
        if (clr_idx_q == IDXW'(LINES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o     = 1'b1;
          cur_req_d   = q_req_i;
          cur_idx_d   = q_idx_i;
          cur_base_d  = AW'(32'(q_idx_i) * 32'(BEATS));
          res_data_d  = '0;
          res_bytes_d = '0;
          if (q_req_i.op == OP_BAD) begin
            state_d = S_ERR;
          end else if (q_req_i.op == OP_FILL) begin
            if (!fill_pending_q) begin
              state_d = S_ERR;
            end else begin
              data_we    = 1'b1;
              data_waddr = held_base_q + AW'(fill_cnt_q);
              data_wdata = q_req_i.wdata;
              fill_cnt_d = fill_cnt_q + BCW'(1);
              if (fill_cnt_q == BCW'(BEATS - 1)) begin
                // install the line clean and resume the held access
                fill_cnt_d     = '0;
                fill_pending_d = 1'b0;
                meta_we        = 1'b1;
                meta_waddr     = held_idx_q;
                meta_wdata     = '{valid: 1'b1, dirty: 1'b0, tag: held_req_q.cluster};
                cur_req_d      = held_req_q;
                cur_idx_d      = held_idx_q;
                cur_base_d     = held_base_q;
                cur_dirty_d    = 1'b0;
                state_d        = S_ACC;
              end
            end
          end else if (fill_pending_q) begin
            state_d = S_ERR;
          end else begin
            state_d = S_META;
          end
        end
      end
      S_ERR: begin
        if (out_ready) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_ERR;
          out_cl_d    = cur_req_q.cluster;
          out_data_d  = '0;
          out_bidx_d  = '0;
          out_bytes_d = '0;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_META: begin
        if (hit) begin
          cur_dirty_d = meta_rdata_q.dirty;
          state_d     = S_ACC;
        end else begin
          meta_we        = 1'b1;
          meta_wdata     = '{valid: 1'b0, dirty: 1'b0, tag: meta_rdata_q.tag};
          fill_pending_d = 1'b1;
          fill_cnt_d     = '0;
          held_req_d     = cur_req_q;
          held_idx_d     = cur_idx_q;
          held_base_d    = cur_base_q;
          if (meta_rdata_q.valid && meta_rdata_q.dirty) begin
            wb_cl_d   = meta_rdata_q.tag;
            wb_miss_d = 1'b1;
            beat_d    = '0;
            state_d   = S_WB_RD;
          end else begin
            state_d = S_FETCH;
          end
        end
      end
      S_ACC: begin
        case (cur_req_q.op)
          OP_READ, OP_WRITE: state_d = S_RD0;
          OP_ZERO: begin
            beat_d  = '0;
            state_d = S_ZERO;
          end
          default: begin
            if (cur_dirty_q) begin
              wb_cl_d   = cur_req_q.cluster;
              wb_miss_d = 1'b0;
              beat_d    = '0;
              state_d   = S_WB_RD;
            end else begin
              state_d = S_DONE;
            end
          end
        endcase
      end
      S_RD0: begin
        data_re    = 1'b1;
        data_raddr = cur_base_q + AW'(cur_req_q.offset[7:3]);
        state_d    = S_RD1;
      end
      S_RD1: begin
        data_re    = 1'b1;
        data_raddr = cur_base_q + AW'(cur_req_q.offset[7:3]) + AW'(1);
        d0_d       = data_rdata_q;
        state_d    = S_RD2;
      end
      S_RD2: begin
        res_bytes_d = nbytes;
        if (cur_req_q.op == OP_READ) begin
          res_data_d = rd_val;
          state_d    = S_DONE;
        end else begin
          res_data_d = '0;
          data_we    = nbytes != 4'd0;
          data_waddr = cur_base_q + AW'(cur_req_q.offset[7:3]);
          data_wdata = merged[63:0];
          hi_word_d  = merged[127:64];
          hi_we_d    = mask16[15:8] != 8'd0;
          state_d    = S_WR1;
        end
      end
      S_WR1: begin
        data_we    = hi_we_q;
        data_waddr = cur_base_q + AW'(cur_req_q.offset[7:3]) + AW'(1);
        data_wdata = hi_word_q;
        meta_we    = 1'b1;
        meta_wdata = '{valid: 1'b1, dirty: 1'b1, tag: cur_req_q.cluster};
        state_d    = S_DONE;
      end
      S_ZERO: begin
        data_we    = 1'b1;
        data_waddr = cur_base_q + AW'(beat_q);
        data_wdata = '0;
        beat_d     = beat_q + BCW'(1);
        if (wb_last) begin
          meta_we    = 1'b1;
          meta_wdata = '{valid: 1'b1, dirty: 1'b1, tag: cur_req_q.cluster};
          state_d    = S_DONE;
        end
      end
      S_WB_RD: begin
        data_re    = 1'b1;
        data_raddr = cur_base_q + AW'(beat_q);
        state_d    = S_WB_EM;
      end
      S_WB_EM: begin
        if (out_ready) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_WB;
          out_cl_d    = wb_cl_q;
          out_data_d  = wb_val;
          out_bidx_d  = 5'(beat_q);
          out_bytes_d = wb_last ? 4'(TAIL) : MAX_BYTES;
          out_last_d  = 1'b0;
          beat_d      = beat_q + BCW'(1);
          if (!wb_last) begin
            state_d = S_WB_RD;
          end else if (wb_miss_q) begin
            state_d = S_FETCH;
          end else begin
            meta_we    = 1'b1;
            meta_wdata = '{valid: 1'b1, dirty: 1'b0, tag: cur_req_q.cluster};
            state_d    = S_DONE;
          end
        end
      end
      S_FETCH: begin
        if (out_ready) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_FETCH;
          out_cl_d    = cur_req_q.cluster;
          out_data_d  = '0;
          out_bidx_d  = '0;
          out_bytes_d = '0;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_DONE: begin
        if (out_ready) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_DONE;
          out_cl_d    = cur_req_q.cluster;
          out_data_d  = res_data_q;
          out_bidx_d  = '0;
          out_bytes_d = res_bytes_q;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      clr_idx_q      <= '0;
      fill_pending_q <= 1'b0;
      fill_cnt_q     <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      clr_idx_q      <= clr_idx_d;
      fill_pending_q <= fill_pending_d;
      fill_cnt_q     <= fill_cnt_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_req_q  <= held_req_d;
    held_idx_q  <= held_idx_d;
    held_base_q <= held_base_d;
    cur_req_q   <= cur_req_d;
    cur_idx_q   <= cur_idx_d;
    cur_base_q  <= cur_base_d;
    cur_dirty_q <= cur_dirty_d;
    beat_q      <= beat_d;
    wb_cl_q     <= wb_cl_d;
    wb_miss_q   <= wb_miss_d;
    d0_q        <= d0_d;
    hi_word_q   <= hi_word_d;
    hi_we_q     <= hi_we_d;
    res_data_q  <= res_data_d;
    res_bytes_q <= res_bytes_d;
    out_kind_q  <= out_kind_d;
    out_cl_q    <= out_cl_d;
    out_data_q  <= out_data_d;
    out_bidx_q  <= out_bidx_d;
    out_bytes_q <= out_bytes_d;
    out_last_q  <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
    meta_rdata_q <= meta_mem[meta_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (data_we) data_mem[data_waddr] <= data_wdata;
    if (data_re) data_rdata_q <= data_mem[data_raddr];
  end

endmodule
`default_nettype wire

FILE: design/direct_mapped_writeback_cache_core.sv
// Channel   Handshake          Payload
// request   push_i / full_o    func_i cluster_i offset_i byte_count_i wdata_i
// result    pop_i / empty_o    kind_o target_cluster_o beat_data_o beat_index_o
//                              bytes_done_o last_o
//
// The front takes a request every cycle while the queue has room when LINES is a
// power of two; otherwise full_o stays high while a reciprocal multiply finds the
// line index. From the back end taking a request, a hit read passes the states META,
// ACC, RD0, RD1, RD2 and DONE; a hit write adds WR1 (two-word read-modify-write on one
// data port); zero-line writes each beat of the line in ZERO before DONE.
// A writeback beat is a memory read, then a result register load.
// After reset the tag memory is cleared with full_o high.
// A stalled result holds the back end; the queue holds two requests, the front one more.
`default_nettype none
module direct_mapped_writeback_cache_core #(
  parameter int LINES         = 16,
  parameter int CLUSTER_BYTES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic [2:0]  func_i,
  input  wire logic [31:0] cluster_i,
  input  wire logic [7:0]  offset_i,
  input  wire logic [3:0]  byte_count_i,
  input  wire logic [63:0] wdata_i,
  output logic             empty_o,
  input  wire logic        pop_i,
  output logic [1:0]       kind_o,
  output logic [31:0]      target_cluster_o,
  output logic [63:0]      beat_data_o,
  output logic [4:0]       beat_index_o,
  output logic [3:0]       bytes_done_o,
  output logic             last_o
);
  import dmwc_pkg::*;

  localparam int IDXW = (LINES > 1) ? $clog2(LINES) : 1;

  logic            clearing;
  logic            fq_full, fq_push, fq_empty, fq_pop;
  req_t            fq_req_in, fq_req_out;
  logic [IDXW-1:0] fq_idx_in, fq_idx_out;

  dmwc_front #(.LINES(LINES), .IDXW(IDXW)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hold_i       (clearing),
    .push_i       (push_i),
    .full_o       (full_o),
    .func_i       (func_i),
    .cluster_i    (cluster_i),
    .offset_i     (offset_i),
    .byte_count_i (byte_count_i),
    .wdata_i      (wdata_i),
    .q_full_i     (fq_full),
    .q_push_o     (fq_push),
    .q_req_o      (fq_req_in),
    .q_idx_o      (fq_idx_in)
  );

  dmwc_fifo #(.IDXW(IDXW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .full_o  (fq_full),
    .req_i   (fq_req_in),
    .idx_i   (fq_idx_in),
    .pop_i   (fq_pop),
    .empty_o (fq_empty),
    .req_o   (fq_req_out),
    .idx_o   (fq_idx_out)
  );

  dmwc_back #(.LINES(LINES), .CLUSTER_BYTES(CLUSTER_BYTES), .IDXW(IDXW)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .clearing_o       (clearing),
    .q_empty_i        (fq_empty),
    .q_req_i          (fq_req_out),
    .q_idx_i          (fq_idx_out),
    .q_pop_o          (fq_pop),
    .empty_o          (empty_o),
    .pop_i            (pop_i),
    .kind_o           (kind_o),
    .target_cluster_o (target_cluster_o),
    .beat_data_o      (beat_data_o),
    .beat_index_o     (beat_index_o),
    .bytes_done_o     (bytes_done_o),
    .last_o           (last_o)
  );

endmodule
`default_nettype wire

FILE: tb/dmwc_checker.sv
`timescale 1ns / 1ps
module dmwc_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire logic        full_i,
  input  wire logic [2:0]  func_i,
  input  wire logic [31:0] cluster_i,
  input  wire logic [7:0]  offset_i,
  input  wire logic [3:0]  byte_count_i,
  input  wire logic [63:0] wdata_i,
  input  wire logic        empty_i,
  input  wire logic        pop_i,
  input  wire logic [1:0]  kind_i,
  input  wire logic [31:0] target_cluster_i,
  input  wire logic [63:0] beat_data_i,
  input  wire logic [4:0]  beat_index_i,
  input  wire logic [3:0]  bytes_done_i,
  input  wire logic        last_i,
  output logic             fill_wait_o,
  output int               outstanding_o,
  output int               errors_o
);
  import dmwc_pkg::*;

  localparam int NLINES = 16;
  localparam int NBYTES = 256;
  localparam int NBEATS = NBYTES / 8;

  typedef struct {
    kind_e       kind;
    logic [31:0] cl;
    logic [63:0] data;
    logic [4:0]  idx;
    logic [3:0]  bytes;
    logic        last;
  } result_t;

  result_t     result_q[$];
  logic        ln_valid[NLINES];
  logic        ln_dirty[NLINES];
  logic [31:0] ln_tag[NLINES];
  logic [7:0]  ln_bytes[NLINES][NBYTES];
  logic        fill_wait;
  logic [2:0]  hold_func;
  logic [31:0] hold_cl;
  logic [7:0]  hold_off;
  logic [3:0]  hold_cnt;
  logic [63:0] hold_wdata;
  int          beats_in;
  int          errors;

  assign fill_wait_o   = fill_wait;
  assign outstanding_o = result_q.size();
  assign errors_o      = errors;

  function automatic void post(kind_e k, logic [31:0] c, logic [63:0] d, logic [4:0] bi,
                               logic [3:0] nb);
    result_t r;
    r.kind = k; r.cl = c; r.data = d; r.idx = bi; r.bytes = nb; r.last = 1'b0;
    result_q.push_back(r);
  endfunction

  function automatic void write_back(int li, logic [31:0] c);
    logic [63:0] d;
    for (int b = 0; b < NBEATS; b++) begin
      for (int j = 0; j < 8; j++) d[8*j +: 8] = ln_bytes[li][b*8 + j];
      post(KIND_WB, c, d, b[4:0], 4'd8);
    end
  endfunction

  function automatic void run_access(int li, logic [2:0] f, logic [31:0] c, logic [7:0] o,
                                     logic [3:0] n, logic [63:0] w);
    int          cnt;
    int          i;
    logic [63:0] d;
    cnt = (n > 8) ? 8 : n;
    d = '0;
    i = 0;
    if (f == FUNC_READ || f == FUNC_WRITE) begin
      while (i < cnt && int'(o) + i < NBYTES) begin
        if (f == FUNC_READ) d[8*i +: 8] = ln_bytes[li][int'(o) + i];
        else ln_bytes[li][int'(o) + i] = w[8*i +: 8];
        i++;
      end
      if (f == FUNC_WRITE) ln_dirty[li] = 1'b1;
      post(KIND_DONE, c, d, 5'd0, i[3:0]);
    end else if (f == FUNC_ZERO) begin
      for (int k = 0; k < NBYTES; k++) ln_bytes[li][k] = 8'h00;
      ln_dirty[li] = 1'b1;
      post(KIND_DONE, c, '0, 5'd0, 4'd0);
    end else begin
      if (ln_dirty[li]) begin
        write_back(li, c);
        ln_dirty[li] = 1'b0;
      end
      post(KIND_DONE, c, '0, 5'd0, 4'd0);
    end
  endfunction

  function automatic void predict_request(logic [2:0] f, logic [31:0] c, logic [7:0] o,
                                          logic [3:0] n, logic [63:0] w);
    int base_cnt;
    int li;
    base_cnt = result_q.size();
    if (f == FUNC_FILL) begin
      if (!fill_wait) begin
        post(KIND_ERR, c, '0, 5'd0, 4'd0);
      end else begin
        li = hold_cl % NLINES;
        for (int j = 0; j < 8; j++) ln_bytes[li][beats_in*8 + j] = w[8*j +: 8];
        beats_in++;
        if (beats_in >= NBEATS) begin
          fill_wait = 1'b0;
          beats_in = 0;
          ln_tag[li] = hold_cl;
          ln_valid[li] = 1'b1;
          ln_dirty[li] = 1'b0;
          run_access(li, hold_func, hold_cl, hold_off, hold_cnt, hold_wdata);
        end
      end
    end else if (f > FUNC_FILL || fill_wait) begin
      post(KIND_ERR, c, '0, 5'd0, 4'd0);
    end else begin
      li = c % NLINES;
      if (ln_valid[li] && ln_tag[li] == c) begin
        run_access(li, f, c, o, n, w);
      end else begin
        if (ln_valid[li] && ln_dirty[li]) write_back(li, ln_tag[li]);
        ln_valid[li] = 1'b0;
        ln_dirty[li] = 1'b0;
        post(KIND_FETCH, c, '0, 5'd0, 4'd0);
        fill_wait = 1'b1;
        beats_in = 0;
        hold_func = f; hold_cl = c; hold_off = o; hold_cnt = n; hold_wdata = w;
      end
    end
    if (result_q.size() > base_cnt) result_q[$].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_q.delete();
      for (int k = 0; k < NLINES; k++) begin
        ln_valid[k] = 1'b0;
        ln_dirty[k] = 1'b0;
      end
      fill_wait = 1'b0;
      beats_in = 0;
      errors = 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: result with nothing expected: kind %0d cluster %h", $time,
                   kind_i, target_cluster_i);
          errors++;
        end else begin
          result_t e;
          e = result_q.pop_front();
          if (kind_i != e.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, e.kind, kind_i);
            errors++;
          end
          if (target_cluster_i != e.cl) begin
            $display("%0t: cluster expected %h actual %h", $time, e.cl, target_cluster_i);
            errors++;
          end
          if (beat_data_i != e.data) begin
            $display("%0t: data expected %h actual %h", $time, e.data, beat_data_i);
            errors++;
          end
          if (beat_index_i != e.idx) begin
            $display("%0t: beat index expected %0d actual %0d", $time, e.idx, beat_index_i);
            errors++;
          end
          if (bytes_done_i != e.bytes) begin
            $display("%0t: bytes expected %0d actual %0d", $time, e.bytes, bytes_done_i);
            errors++;
          end
          if (last_i != e.last) begin
            $display("%0t: last expected %0d actual %0d", $time, e.last, last_i);
            errors++;
          end
        end
      end
      if (push_i && !full_i)
        predict_request(func_i, cluster_i, offset_i, byte_count_i, wdata_i);
    end
  end

endmodule

FILE: tb/direct_mapped_writeback_cache_core_test.sv
`timescale 1ns / 1ps
module direct_mapped_writeback_cache_core_test;
  import dmwc_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic [2:0]  func = FUNC_READ;
  logic [31:0] cluster = '0;
  logic [7:0]  offset = '0;
  logic [3:0]  byte_count = '0;
  logic [63:0] wdata = '0;
  logic        pop = 1'b0;
  logic        full, empty, last;
  logic [1:0]  kind;
  logic [31:0] target_cluster;
  logic [63:0] beat_data;
  logic [4:0]  beat_index;
  logic [3:0]  bytes_done;
  logic        fill_wait;
  int          outstanding;
  int          errors;
  int          tx_idle_pct = 26;
  int          rx_stall_pct = 73;
  int          cycles = 0;

  always #10 clk = ~clk;

  direct_mapped_writeback_cache_core dut (
    .clk_i(clk), .rst_ni(rst_n), .push_i(push), .full_o(full),
    .func_i(func), .cluster_i(cluster), .offset_i(offset), .byte_count_i(byte_count),
    .wdata_i(wdata), .empty_o(empty), .pop_i(pop), .kind_o(kind),
    .target_cluster_o(target_cluster), .beat_data_o(beat_data),
    .beat_index_o(beat_index), .bytes_done_o(bytes_done), .last_o(last)
  );

  dmwc_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .push_i(push), .full_i(full), .func_i(func),
    .cluster_i(cluster), .offset_i(offset), .byte_count_i(byte_count), .wdata_i(wdata),
    .empty_i(empty), .pop_i(pop), .kind_i(kind), .target_cluster_i(target_cluster),
    .beat_data_i(beat_data), .beat_index_i(beat_index), .bytes_done_i(bytes_done),
    .last_i(last), .fill_wait_o(fill_wait), .outstanding_o(outstanding),
    .errors_o(errors)
  );

  always @(negedge clk) pop <= ($urandom_range(99) >= rx_stall_pct);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send(logic [2:0] f, logic [31:0] c, logic [7:0] o, logic [3:0] n,
                      logic [63:0] w);
    if ($urandom_range(99) < tx_idle_pct) begin
      push = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    func = f; cluster = c; offset = o; byte_count = n; wdata = w;
    push = 1'b1;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // Send one access; if it missed, stream the fill, with optional noise mid-fill.
  task automatic access(logic [2:0] f, logic [31:0] c, logic [7:0] o, logic [3:0] n,
                        logic [63:0] w, int noise_pct);
    send(f, c, o, n, w);
    while (fill_wait) begin
      if ($urandom_range(99) < noise_pct)
        send(3'($urandom_range(0, 3)), $urandom, 8'($urandom), 4'($urandom),
             {$urandom, $urandom});
      else
        send(FUNC_FILL, $urandom, 8'($urandom), 4'($urandom), {$urandom, $urandom});
    end
  endtask

  function automatic logic [31:0] pick_cluster();
    return ($urandom_range(99) < 85) ? 32'($urandom_range(0, 47)) : 32'($urandom);
  endfunction

  initial begin
    logic [2:0] f;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed
    access(FUNC_READ, 32'd0, 8'd0, 4'd8, '0, 0);
    access(FUNC_WRITE, 32'd0, 8'd0, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    access(FUNC_WRITE, 32'd0, 8'd255, 4'd15, 64'h0123_4567_89AB_CDEF, 0);
    access(FUNC_WRITE, 32'd0, 8'd8, 4'd0, 64'h5555_5555_5555_5555, 0);
    access(FUNC_READ, 32'd0, 8'd0, 4'd15, '0, 0);
    access(FUNC_READ, 32'd0, 8'd252, 4'd8, '0, 0);
    access(FUNC_READ, 32'd0, 8'd3, 4'd0, '0, 0);
    access(FUNC_FLUSH, 32'd0, '0, '0, '0, 0);
    access(FUNC_FLUSH, 32'd0, '0, '0, '0, 0);
    access(FUNC_ZERO, 32'd0, '0, '0, '0, 0);
    access(FUNC_WRITE, 32'd16, 8'd7, 4'd1, 64'hAA, 0);
    access(FUNC_ZERO, 32'hFFFF_FFFF, '0, '0, '0, 0);
    access(FUNC_FLUSH, 32'hFFFF_FFF0, '0, '0, '0, 0);
    access(FUNC_READ, 32'hFFFF_FFFF, 8'd128, 4'd8, '0, 0);
    send(FUNC_FILL, 32'h1234_5678, '0, '0, '1);
    send(3'd5, 32'd1, '0, '0, '0);
    send(3'd6, 32'd2, '0, '0, '0);
    send(3'd7, 32'hFFFF_FFFF, 8'hFF, 4'hF, '1);
    send(FUNC_READ, 32'd5, '0, 4'd4, '0);
    send(FUNC_WRITE, 32'd6, '0, 4'd4, '1);
    while (fill_wait) send(FUNC_FILL, '0, '0, '0, {$urandom, $urandom});

    // random
    for (int k = 0; k < 100; k++) begin
      if (k == 33) begin
        tx_idle_pct = 73;
        rx_stall_pct = 26;
      end else if (k == 66) begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end
      if ($urandom_range(99) < 10) begin
        f = ($urandom_range(1) == 1) ? FUNC_FILL : 3'($urandom_range(5, 7));
        send(f, $urandom, 8'($urandom), 4'($urandom), {$urandom, $urandom});
      end else begin
        f = ($urandom_range(99) < 80) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(2, 3));
        access(f, pick_cluster(),
               ($urandom_range(3) == 0) ? 8'($urandom_range(240, 255)) : 8'($urandom),
               4'($urandom), {$urandom, $urandom}, 3);
      end
    end
    push = 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
